// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker module. Clock and reset come from
// the scope of the module that uses them (clk, rst_n).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, off while reset is held
`define CIP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also runs during reset
`define CIP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/cip_pkg.sv
// ----------------------------------------------------------------------------
// cip_pkg
// Widths, field offsets, register indexes and constants of the cone
// isolation pt sum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cip_pkg;

  // Sizes
  localparam int NUM_CONES  = 4;
  localparam int CONE_W     = 28;
  localparam int NCONE_W    = 3;
  localparam int NEXCL_W    = 2;
  localparam int ETA_W      = 16;
  localparam int PHI_W      = 15;
  localparam int PT_W       = 32;
  localparam int TYPE_W     = 25;
  localparam int UID_W      = 31;
  localparam int SUM_W      = 40;

  // Intermediate widths
  localparam int DPHI_W     = PHI_W + 1;    // signed phi difference
  localparam int DPHI_ABS_W = PHI_W;        // its magnitude
  localparam int DETA_W     = ETA_W + 1;    // signed eta difference
  localparam int DETA_ABS_W = ETA_W;        // its magnitude
  localparam int DPHI2_W    = 28;           // wrapped dphi is at most pi
  localparam int DETA2_W    = 2 * DETA_ABS_W;
  localparam int DR2_W      = DETA2_W + 1;

  // Config port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = CONE_W;

  // Stream payload layout
  localparam int ETA_LSB    = 0;
  localparam int PHI_LSB    = ETA_LSB + ETA_W;
  localparam int PT_LSB     = PHI_LSB + PHI_W;
  localparam int TYPE_LSB   = PT_LSB + PT_W;
  localparam int UID_LSB    = TYPE_LSB + TYPE_W;
  localparam int IN_BITS    = UID_LSB + UID_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = NUM_CONES * SUM_W;

  // Angle constants in Q3.12
  localparam int PI_Q       = 12868;
  localparam int TWO_PI_Q   = 25736;

  // Reset value of the first cone register
  localparam logic [CONE_W-1:0] CONE_SQ_0_RST = CONE_W'(671089);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CONE_SQ_0    = 3'd0,
    REG_CONE_SQ_1    = 3'd1,
    REG_CONE_SQ_2    = 3'd2,
    REG_CONE_SQ_3    = 3'd3,
    REG_CONES_IN_USE = 3'd4,
    REG_EXCL_A       = 3'd5,
    REG_EXCL_B       = 3'd6,
    REG_EXCL_COUNT   = 3'd7
  } cfg_reg_t;

  // Item kinds
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_CAND = 1'b1
  } action_t;

  typedef logic [SUM_W-1:0] sum_t;

endpackage

// File: sv/cone_isolation_pt_sum_top.sv
// ----------------------------------------------------------------------------
// cone_isolation_pt_sum_top
// Cone isolation pt sum: holds a reference particle, sums candidate pt into
// up to four cones by squared delta R, emits the sums on the last item.
//
//   channel  dir  handshake           payload
//   in_      in   tvalid/tready       tuser: action; tdata: eta, phi, pt,
//                                     type_id, unique_id; tlast: last
//   out_     out  tvalid/tready       tdata: iso_sum_0..iso_sum_3
//   cfg_     in   wr_en (no wait)     addr: register index; wdata: value
//
// One item per cycle while the input is not stalled. An item passes the input
// register, the distance stage (two squares and an add), then the compare and
// accumulate stage that feeds the output register.
// Reset (rst_n low, synchronous) sets config registers to their reset values and clears reference, sums and valids.
// The input stalls only when a second result reaches the last stage while
// the output register still holds one that has not been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cone_isolation_pt_sum_top
  import cip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // config write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // eta, phi, pt, type_id, unique_id, pad
  input  logic                  in_tuser,   // action
  input  logic                  in_tlast,
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // iso_sum_0, iso_sum_1, iso_sum_2, iso_sum_3
);

  // Config registers
  logic [CONE_W-1:0]        cone_sq_r [NUM_CONES];
  logic [NCONE_W-1:0]       cones_in_use_r;
  logic signed [TYPE_W-1:0] excl_a_r;
  logic signed [TYPE_W-1:0] excl_b_r;
  logic [NEXCL_W-1:0]       excl_count_r;

  // Write config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cone_sq_r[0]   <= CONE_SQ_0_RST;
      for (int i = 1; i < NUM_CONES; i++) begin
        cone_sq_r[i] <= '0;
      end
      cones_in_use_r <= NCONE_W'(1);
      excl_a_r       <= '0;
      excl_b_r       <= '0;
      excl_count_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_CONE_SQ_0:    cone_sq_r[0]   <= cfg_wdata;
        REG_CONE_SQ_1:    cone_sq_r[1]   <= cfg_wdata;
        REG_CONE_SQ_2:    cone_sq_r[2]   <= cfg_wdata;
        REG_CONE_SQ_3:    cone_sq_r[3]   <= cfg_wdata;
        REG_CONES_IN_USE: cones_in_use_r <= cfg_wdata[NCONE_W-1:0];
        REG_EXCL_A:       excl_a_r       <= signed'(cfg_wdata[TYPE_W-1:0]);
        REG_EXCL_B:       excl_b_r       <= signed'(cfg_wdata[TYPE_W-1:0]);
        REG_EXCL_COUNT:   excl_count_r   <= cfg_wdata[NEXCL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic s1_v_r, s2_v_r, out_valid_r;
  logic s2_last_r;
  logic out_free, s2_go, s2_en, s1_go, s1_en, in_acc;

  assign out_free  = !out_valid_r || out_tready;
  assign s2_go     = s2_v_r && (!s2_last_r || out_free);
  assign s2_en     = !s2_v_r || s2_go;
  assign s1_go     = s1_v_r && s2_en;
  assign s1_en     = !s1_v_r || s2_en;
  assign in_tready = s1_en;
  assign in_acc    = in_tvalid && s1_en;

  // Stage 1: input register
  action_t                  s1_act_r;
  logic signed [ETA_W-1:0]  s1_eta_r;
  logic signed [PHI_W-1:0]  s1_phi_r;
  logic [PT_W-1:0]          s1_pt_r;
  logic signed [TYPE_W-1:0] s1_type_r;
  logic [UID_W-1:0]         s1_uid_r;
  logic                     s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_act_r  <= action_t'(in_tuser);
      s1_eta_r  <= signed'(in_tdata[ETA_LSB +: ETA_W]);
      s1_phi_r  <= signed'(in_tdata[PHI_LSB +: PHI_W]);
      s1_pt_r   <= in_tdata[PT_LSB +: PT_W];
      s1_type_r <= signed'(in_tdata[TYPE_LSB +: TYPE_W]);
      s1_uid_r  <= in_tdata[UID_LSB +: UID_W];
      s1_last_r <= in_tlast;
    end
  end

  // Reference particle, taken when a load item leaves stage 1
  logic signed [ETA_W-1:0] ref_eta_r;
  logic signed [PHI_W-1:0] ref_phi_r;
  logic [UID_W-1:0]        ref_uid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_eta_r <= '0;
      ref_phi_r <= '0;
      ref_uid_r <= '0;
    end else if (s1_go && s1_act_r == ACT_LOAD) begin
      ref_eta_r <= s1_eta_r;
      ref_phi_r <= s1_phi_r;
      ref_uid_r <= s1_uid_r;
    end
  end

  // Distance: wrapped dphi and deta, squared and summed
  logic signed [DPHI_W-1:0]   dphi_diff;
  logic [DPHI_ABS_W-1:0]      dphi_abs;
  logic signed [DPHI_W-1:0]   dphi_wrap;
  logic signed [2*DPHI_W-1:0] dphi_sq;
  logic signed [DETA_W-1:0]   deta_diff;
  logic [DETA_ABS_W-1:0]      deta_abs;
  logic [DETA2_W-1:0]         deta_sq;
  logic [DR2_W-1:0]           dr2;
  logic                       excl_hit;
  logic                       skip;

  always_comb begin
    dphi_diff = DPHI_W'(s1_phi_r) - DPHI_W'(ref_phi_r);
    dphi_abs  = dphi_diff[DPHI_W-1] ? DPHI_ABS_W'(-dphi_diff)
                                    : dphi_diff[DPHI_ABS_W-1:0];
    // fold back past pi
    if (dphi_abs > DPHI_ABS_W'(PI_Q)) begin
      dphi_wrap = signed'(DPHI_W'(TWO_PI_Q)) - signed'({1'b0, dphi_abs});
    end else begin
      dphi_wrap = signed'({1'b0, dphi_abs});
    end
    dphi_sq   = dphi_wrap * dphi_wrap;

    deta_diff = DETA_W'(s1_eta_r) - DETA_W'(ref_eta_r);
    deta_abs  = deta_diff[DETA_W-1] ? DETA_ABS_W'(-deta_diff)
                                    : deta_diff[DETA_ABS_W-1:0];
    deta_sq   = deta_abs * deta_abs;

    dr2       = DR2_W'(dphi_sq[DPHI2_W-1:0]) + DR2_W'(deta_sq);

    // drop excluded types and the reference itself
    excl_hit  = (excl_count_r >= NEXCL_W'(1) && s1_type_r == excl_a_r) ||
                (excl_count_r >= NEXCL_W'(2) && s1_type_r == excl_b_r);
    skip      = excl_hit || (s1_uid_r == ref_uid_r);
  end

  // Stage 2: distance register
  logic             s2_load_r;
  logic             s2_add_r;
  logic [DR2_W-1:0] s2_dr2_r;
  logic [PT_W-1:0]  s2_pt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_load_r <= (s1_act_r == ACT_LOAD);
      s2_add_r  <= (s1_act_r == ACT_CAND) && !skip;
      s2_dr2_r  <= dr2;
      s2_pt_r   <= s1_pt_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Compare against each cone and accumulate with saturation
  sum_t             sums_r   [NUM_CONES];
  sum_t             sums_nxt [NUM_CONES];
  logic [SUM_W:0]   sum_wide [NUM_CONES];
  logic [OUT_DATA_W-1:0] out_data_nxt;

  always_comb begin
    for (int i = 0; i < NUM_CONES; i++) begin
      sum_wide[i] = {1'b0, sums_r[i]} + (SUM_W + 1)'(s2_pt_r);
      if (s2_load_r) begin
        sums_nxt[i] = '0;
      end else if (s2_add_r && NCONE_W'(i) < cones_in_use_r &&
                   s2_dr2_r < DR2_W'(cone_sq_r[i])) begin
        sums_nxt[i] = sum_wide[i][SUM_W] ? SUM_MAX : sum_wide[i][SUM_W-1:0];
      end else begin
        sums_nxt[i] = sums_r[i];
      end
      out_data_nxt[i*SUM_W +: SUM_W] =
        (NCONE_W'(i) < cones_in_use_r) ? sums_nxt[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CONES; i++) begin
        sums_r[i] <= '0;
      end
    end else if (s2_go) begin
      for (int i = 0; i < NUM_CONES; i++) begin
        sums_r[i] <= sums_nxt[i];
      end
    end
  end

  // Output register: load on a last item, hold until taken
  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go && s2_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_last_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: sv/cip_checker.sv
// ----------------------------------------------------------------------------
// cip_checker
// Port-level checks of the cone isolation pt sum block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cip_checker
  import cip_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // Reset empties the output register
  `CIP_ASSERT_RST(a_rst_out_empty, !rst_n |=> !out_tvalid, "out_tvalid set after reset")

  // Input backpressure only comes from a result that is waiting to be taken
  `CIP_ASSERT(a_stall_cause, !in_tready |-> out_tvalid && !out_tready, "input stalled without cause")

  // A result held by the sink stays put
  `CIP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // A result leaves only by being taken
  `CIP_ASSERT(a_out_taken, $fell(out_tvalid) |-> $past(out_tready), "result dropped without handshake")

endmodule

bind cone_isolation_pt_sum_top cip_checker u_cip_checker (.*);
